FILE: rtl/i2cdw_pkg.sv
// Package: phase codes, result bundle and register constants for the I2C display write master.
package i2cdw_pkg;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_SDA = 4'd1,
    PH_START_SCL = 4'd2,
    PH_BIT_SDA   = 4'd3,
    PH_BIT_HI    = 4'd4,
    PH_BIT_LO    = 4'd5,
    PH_ACK_REL   = 4'd6,
    PH_ACK_WAIT  = 4'd7,
    PH_ACK_LO    = 4'd8,
    PH_STOP_SDA  = 4'd9,
    PH_STOP_SCL  = 4'd10,
    PH_STOP_END  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    SLOT_ADDR = 2'd0,
    SLOT_CTRL = 2'd1,
    SLOT_DATA = 2'd2
  } slot_e;

  // Configuration register indexes
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] DEV_ADDR_RST    = 8'h78;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
  localparam logic [7:0] CTRL_DATA       = 8'h40;
  localparam logic [7:0] CTRL_CMD        = 8'h00;

  localparam logic [2:0] BIT_LAST = 3'd7;

  // One step result, as seen on the bus pins plus status
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
    logic busy;
    logic done;
    logic err;
  } result_t;

endpackage

FILE: rtl/i2cdw_engine.sv
// Transaction sequencer: phase state machine, bit shifter, ack wait counter and pin state.
module i2cdw_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                req_i,
  input  logic [7:0]          payload_i,
  input  logic                is_data_i,
  input  logic                sda_sense_i,
  input  logic [7:0]          dev_addr_i,
  input  logic [7:0]          ack_timeout_i,
  output i2cdw_pkg::result_t  res_o
);

  i2cdw_pkg::phase_e phase_q, phase_d;
  i2cdw_pkg::slot_e  slot_q, slot_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] held_payload_q, held_payload_d;
  logic       held_kind_q, held_kind_d;
  logic [7:0] wait_q, wait_d;
  logic       err_q, err_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic       done_d;

  logic [7:0] wait_dec;
  logic       ack_timeout_hit;
  logic       byte_end;

  assign wait_dec        = wait_q - 8'd1;
  assign ack_timeout_hit = sda_sense_i && (wait_dec == 8'd0);
  // leave the ack phase: either after the ack pulse or on timeout
  assign byte_end = (phase_q == i2cdw_pkg::PH_ACK_LO) ||
                    ((phase_q == i2cdw_pkg::PH_ACK_WAIT) && ack_timeout_hit);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      i2cdw_pkg::PH_START_SDA: if (!req_i) phase_d = i2cdw_pkg::PH_START_SCL;
      i2cdw_pkg::PH_START_SCL: if (!req_i) phase_d = i2cdw_pkg::PH_BIT_SDA;
      i2cdw_pkg::PH_BIT_SDA:   if (!req_i) phase_d = i2cdw_pkg::PH_BIT_HI;
      i2cdw_pkg::PH_BIT_HI:    if (!req_i) phase_d = i2cdw_pkg::PH_BIT_LO;
      i2cdw_pkg::PH_BIT_LO: begin
        if (!req_i) begin
          phase_d = (bit_cnt_q == i2cdw_pkg::BIT_LAST) ? i2cdw_pkg::PH_ACK_REL
                                                       : i2cdw_pkg::PH_BIT_SDA;
        end
      end
      i2cdw_pkg::PH_ACK_REL:   if (!req_i) phase_d = i2cdw_pkg::PH_ACK_WAIT;
      i2cdw_pkg::PH_ACK_WAIT, i2cdw_pkg::PH_ACK_LO: begin
        if (!req_i) begin
          if (phase_q == i2cdw_pkg::PH_ACK_WAIT && !sda_sense_i) begin
            phase_d = i2cdw_pkg::PH_ACK_LO;
          end else if (byte_end) begin
            phase_d = (slot_q == i2cdw_pkg::SLOT_ADDR || slot_q == i2cdw_pkg::SLOT_CTRL)
                      ? i2cdw_pkg::PH_BIT_SDA : i2cdw_pkg::PH_STOP_SDA;
          end
        end
      end
      i2cdw_pkg::PH_STOP_SDA:  if (!req_i) phase_d = i2cdw_pkg::PH_STOP_SCL;
      i2cdw_pkg::PH_STOP_SCL:  if (!req_i) phase_d = i2cdw_pkg::PH_STOP_END;
      i2cdw_pkg::PH_STOP_END:  if (!req_i) phase_d = i2cdw_pkg::PH_IDLE;
      default: begin
        // idle and unused codes: start on request
        phase_d = req_i ? i2cdw_pkg::PH_START_SDA : i2cdw_pkg::PH_IDLE;
      end
    endcase
  end

  // Datapath and pin updates
  always_comb begin
    slot_d         = slot_q;
    bit_cnt_d      = bit_cnt_q;
    shift_d        = shift_q;
    held_payload_d = held_payload_q;
    held_kind_d    = held_kind_q;
    wait_d         = wait_q;
    err_d          = err_q;
    scl_d          = scl_q;
    sda_d          = sda_q;
    drv_d          = drv_q;
    done_d         = 1'b0;
    case (phase_q)
      i2cdw_pkg::PH_START_SDA: if (!req_i) sda_d = 1'b0;
      i2cdw_pkg::PH_START_SCL: begin
        if (!req_i) begin
          scl_d     = 1'b0;
          slot_d    = i2cdw_pkg::SLOT_ADDR;
          shift_d   = dev_addr_i;
          bit_cnt_d = '0;
        end
      end
      i2cdw_pkg::PH_BIT_SDA: begin
        if (!req_i) begin
          drv_d = 1'b1;
          sda_d = shift_q[7];
        end
      end
      i2cdw_pkg::PH_BIT_HI: if (!req_i) scl_d = 1'b1;
      i2cdw_pkg::PH_BIT_LO: begin
        if (!req_i) begin
          scl_d   = 1'b0;
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_cnt_q != i2cdw_pkg::BIT_LAST) bit_cnt_d = bit_cnt_q + 3'd1;
        end
      end
      i2cdw_pkg::PH_ACK_REL: begin
        if (!req_i) begin
          sda_d  = 1'b1;
          drv_d  = 1'b0;
          wait_d = ack_timeout_i;
        end
      end
      i2cdw_pkg::PH_ACK_WAIT, i2cdw_pkg::PH_ACK_LO: begin
        if (!req_i) begin
          if (phase_q == i2cdw_pkg::PH_ACK_WAIT) begin
            if (!sda_sense_i) begin
              scl_d = 1'b1;
            end else begin
              wait_d = wait_dec;
              if (ack_timeout_hit) err_d = 1'b1;
            end
          end
          if (byte_end) begin
            scl_d = 1'b0;
            case (slot_q)
              i2cdw_pkg::SLOT_ADDR: begin
                slot_d    = i2cdw_pkg::SLOT_CTRL;
                shift_d   = held_kind_q ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD;
                bit_cnt_d = '0;
              end
              i2cdw_pkg::SLOT_CTRL: begin
                slot_d    = i2cdw_pkg::SLOT_DATA;
                shift_d   = held_payload_q;
                bit_cnt_d = '0;
              end
              default: ;
            endcase
          end
        end
      end
      i2cdw_pkg::PH_STOP_SDA: begin
        if (!req_i) begin
          drv_d = 1'b1;
          sda_d = 1'b0;
        end
      end
      i2cdw_pkg::PH_STOP_SCL: if (!req_i) scl_d = 1'b1;
      i2cdw_pkg::PH_STOP_END: begin
        if (!req_i) begin
          sda_d  = 1'b1;
          done_d = 1'b1;
        end
      end
      default: begin
        if (req_i) begin
          held_payload_d = payload_i;
          held_kind_d    = is_data_i;
          err_d          = 1'b0;
          slot_d         = i2cdw_pkg::SLOT_ADDR;
          bit_cnt_d      = '0;
          scl_d          = 1'b1;
          sda_d          = 1'b1;
          drv_d          = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= i2cdw_pkg::PH_IDLE;
      slot_q         <= i2cdw_pkg::SLOT_ADDR;
      bit_cnt_q      <= '0;
      shift_q        <= '0;
      held_payload_q <= '0;
      held_kind_q    <= 1'b0;
      wait_q         <= '0;
      err_q          <= 1'b0;
      scl_q          <= 1'b1;
      sda_q          <= 1'b1;
      drv_q          <= 1'b1;
    end else if (advance_i) begin
      phase_q        <= phase_d;
      slot_q         <= slot_d;
      bit_cnt_q      <= bit_cnt_d;
      shift_q        <= shift_d;
      held_payload_q <= held_payload_d;
      held_kind_q    <= held_kind_d;
      wait_q         <= wait_d;
      err_q          <= err_d;
      scl_q          <= scl_d;
      sda_q          <= sda_d;
      drv_q          <= drv_d;
    end
  end

  assign res_o.scl  = scl_d;
  assign res_o.sda  = sda_d;
  assign res_o.drv  = drv_d;
  assign res_o.busy = (phase_d != i2cdw_pkg::PH_IDLE);
  assign res_o.done = done_d;
  assign res_o.err  = err_d;

  // SDA is released only around the acknowledge slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drv_q |-> (phase_q == i2cdw_pkg::PH_ACK_WAIT || phase_q == i2cdw_pkg::PH_ACK_LO ||
                phase_q == i2cdw_pkg::PH_BIT_SDA || phase_q == i2cdw_pkg::PH_STOP_SDA))
    else $error("SDA released outside acknowledge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> $past(phase_q) == i2cdw_pkg::PH_ACK_WAIT)
    else $error("ack error set outside ack wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> (phase_q == i2cdw_pkg::PH_STOP_END && phase_d == i2cdw_pkg::PH_IDLE))
    else $error("done outside stop end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && phase_q == i2cdw_pkg::PH_IDLE && req_i) |=> (err_q == 1'b0 && scl_q && sda_q))
    else $error("request did not reset pins and error");

endmodule

FILE: rtl/i2c_display_write_master.sv
// Top level: stream ports, configuration registers, output register around the sequencer.
//
// Channel  Dir  tdata (low bit up)                     tuser / tlast
// s_axis   in   payload[7:0], sda_sense, pad           tuser: cmd, is_data
// m_axis   out  scl, sda, sda_drive, busy, ack_error   tlast: done
// cfg      in   index 0 device address, 1 ack timeout  -
//
// One request per clock while m_axis is not stalled: each accepted item advances
// the sequencer by one pin phase and its result is registered in the same cycle.
// The output register frees in the cycle its result is taken, so a new item enters
// every cycle while m_axis_tready is high; a stall on m_axis holds s_axis_tready low.
// Reset puts the pins at SCL high, SDA high driven, idle, with the register defaults.
module i2c_display_write_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // payload[7:0], sda_sense[8], zero[15:9]
  input  logic [1:0]  s_axis_tuser,   // cmd[0], is_data[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // scl[0], sda[1], sda_drive[2], busy[3], ack_error[4]
  output logic        m_axis_tlast,   // done
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0] dev_addr_q;
  logic [7:0] ack_timeout_q;
  logic       out_valid_q;
  i2cdw_pkg::result_t out_q;
  i2cdw_pkg::result_t res;
  logic       accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= i2cdw_pkg::DEV_ADDR_RST;
      ack_timeout_q <= i2cdw_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cdw_pkg::CFG_DEV_ADDR:    dev_addr_q    <= cfg_wdata_i;
        i2cdw_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2cdw_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (accept),
    .req_i         (s_axis_tuser[0]),
    .payload_i     (s_axis_tdata[7:0]),
    .is_data_i     (s_axis_tuser[1]),
    .sda_sense_i   (s_axis_tdata[8]),
    .dev_addr_i    (dev_addr_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.err, out_q.busy, out_q.drv, out_q.sda, out_q.scl};
  assign m_axis_tlast  = out_q.done;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[3])
    else $error("done reported while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while result stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> m_axis_tdata[1])
    else $error("released SDA not reported high");

endmodule
